@@ src/sha_md_pkg.sv @@
// Shared types, constants and functions of the multi-mode SHA digest block.
// Holds the round constants, initial hash values and rotation helpers.
// Depends on nothing; used by sha_multi_mode_digest.
package sha_md_pkg;

  // Algorithm codes held in the mode register.
  localparam logic [1:0] MODE_SHA1   = 2'd0;
  localparam logic [1:0] MODE_SHA256 = 2'd1;
  localparam logic [1:0] MODE_SHA384 = 2'd2;
  localparam logic [1:0] MODE_SHA512 = 2'd3;

  // Command codes of an input word.
  localparam logic [1:0] CMD_ABSORB     = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FIN = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;
  localparam logic [1:0] CMD_NONE       = 2'd3;

  // SHA-1 round constants.
  localparam logic [31:0] K1_0 = 32'h5a827999;
  localparam logic [31:0] K1_1 = 32'h6ed9eba1;
  localparam logic [31:0] K1_2 = 32'h8f1bbcdc;
  localparam logic [31:0] K1_3 = 32'hca62c1d6;

  // Padding marker and where the length field starts in a wide and in a narrow block.
  localparam logic [7:0] PAD_MARKER  = 8'h80;
  localparam logic [6:0] LEN_POS_W64 = 7'd112;
  localparam logic [6:0] LEN_POS_W32 = 7'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_e;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    rotr32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    rotr64 = (x >> n) | (x << (64 - n));
  endfunction

  // Initial hash value i of the given mode.
  function automatic logic [63:0] init_value(input logic [1:0] mode, input logic [2:0] i);
    logic [63:0] v512;
    logic [63:0] v384;
    logic [31:0] v1;
    unique case (i)
      3'd0: begin v512 = 64'h6a09e667f3bcc908; v384 = 64'hcbbb9d5dc1059ed8; v1 = 32'h67452301; end
      3'd1: begin v512 = 64'hbb67ae8584caa73b; v384 = 64'h629a292a367cd507; v1 = 32'hefcdab89; end
      3'd2: begin v512 = 64'h3c6ef372fe94f82b; v384 = 64'h9159015a3070dd17; v1 = 32'h98badcfe; end
      3'd3: begin v512 = 64'ha54ff53a5f1d36f1; v384 = 64'h152fecd8f70e5939; v1 = 32'h10325476; end
      3'd4: begin v512 = 64'h510e527fade682d1; v384 = 64'h67332667ffc00b31; v1 = 32'hc3d2e1f0; end
      3'd5: begin v512 = 64'h9b05688c2b3e6c1f; v384 = 64'h8eb44a8768581511; v1 = 32'h0; end
      3'd6: begin v512 = 64'h1f83d9abfb41bd6b; v384 = 64'hdb0c2e0d64f98fa7; v1 = 32'h0; end
      default: begin
        v512 = 64'h5be0cd19137e2179; v384 = 64'h47b5481dbefa4fa4; v1 = 32'h0;
      end
    endcase
    unique case (mode)
      MODE_SHA1:   init_value = {32'h0, v1};
      MODE_SHA256: init_value = {32'h0, v512[63:32]};
      MODE_SHA384: init_value = v384;
      default:     init_value = v512;
    endcase
  endfunction

  // SHA-512 round constants; the top halves serve SHA-256.
  function automatic logic [63:0] round_const(input logic [6:0] t);
    unique case (t)
      7'd0:  round_const = 64'h428a2f98d728ae22;
      7'd1:  round_const = 64'h7137449123ef65cd;
      7'd2:  round_const = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_const = 64'he9b5dba58189dbbc;
      7'd4:  round_const = 64'h3956c25bf348b538;
      7'd5:  round_const = 64'h59f111f1b605d019;
      7'd6:  round_const = 64'h923f82a4af194f9b;
      7'd7:  round_const = 64'hab1c5ed5da6d8118;
      7'd8:  round_const = 64'hd807aa98a3030242;
      7'd9:  round_const = 64'h12835b0145706fbe;
      7'd10: round_const = 64'h243185be4ee4b28c;
      7'd11: round_const = 64'h550c7dc3d5ffb4e2;
      7'd12: round_const = 64'h72be5d74f27b896f;
      7'd13: round_const = 64'h80deb1fe3b1696b1;
      7'd14: round_const = 64'h9bdc06a725c71235;
      7'd15: round_const = 64'hc19bf174cf692694;
      7'd16: round_const = 64'he49b69c19ef14ad2;
      7'd17: round_const = 64'hefbe4786384f25e3;
      7'd18: round_const = 64'h0fc19dc68b8cd5b5;
      7'd19: round_const = 64'h240ca1cc77ac9c65;
      7'd20: round_const = 64'h2de92c6f592b0275;
      7'd21: round_const = 64'h4a7484aa6ea6e483;
      7'd22: round_const = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_const = 64'h76f988da831153b5;
      7'd24: round_const = 64'h983e5152ee66dfab;
      7'd25: round_const = 64'ha831c66d2db43210;
      7'd26: round_const = 64'hb00327c898fb213f;
      7'd27: round_const = 64'hbf597fc7beef0ee4;
      7'd28: round_const = 64'hc6e00bf33da88fc2;
      7'd29: round_const = 64'hd5a79147930aa725;
      7'd30: round_const = 64'h06ca6351e003826f;
      7'd31: round_const = 64'h142929670a0e6e70;
      7'd32: round_const = 64'h27b70a8546d22ffc;
      7'd33: round_const = 64'h2e1b21385c26c926;
      7'd34: round_const = 64'h4d2c6dfc5ac42aed;
      7'd35: round_const = 64'h53380d139d95b3df;
      7'd36: round_const = 64'h650a73548baf63de;
      7'd37: round_const = 64'h766a0abb3c77b2a8;
      7'd38: round_const = 64'h81c2c92e47edaee6;
      7'd39: round_const = 64'h92722c851482353b;
      7'd40: round_const = 64'ha2bfe8a14cf10364;
      7'd41: round_const = 64'ha81a664bbc423001;
      7'd42: round_const = 64'hc24b8b70d0f89791;
      7'd43: round_const = 64'hc76c51a30654be30;
      7'd44: round_const = 64'hd192e819d6ef5218;
      7'd45: round_const = 64'hd69906245565a910;
      7'd46: round_const = 64'hf40e35855771202a;
      7'd47: round_const = 64'h106aa07032bbd1b8;
      7'd48: round_const = 64'h19a4c116b8d2d0c8;
      7'd49: round_const = 64'h1e376c085141ab53;
      7'd50: round_const = 64'h2748774cdf8eeb99;
      7'd51: round_const = 64'h34b0bcb5e19b48a8;
      7'd52: round_const = 64'h391c0cb3c5c95a63;
      7'd53: round_const = 64'h4ed8aa4ae3418acb;
      7'd54: round_const = 64'h5b9cca4f7763e373;
      7'd55: round_const = 64'h682e6ff3d6b2b8a3;
      7'd56: round_const = 64'h748f82ee5defb2fc;
      7'd57: round_const = 64'h78a5636f43172f60;
      7'd58: round_const = 64'h84c87814a1f0ab72;
      7'd59: round_const = 64'h8cc702081a6439ec;
      7'd60: round_const = 64'h90befffa23631e28;
      7'd61: round_const = 64'ha4506cebde82bde9;
      7'd62: round_const = 64'hbef9a3f7b2c67915;
      7'd63: round_const = 64'hc67178f2e372532b;
      7'd64: round_const = 64'hca273eceea26619c;
      7'd65: round_const = 64'hd186b8c721c0c207;
      7'd66: round_const = 64'heada7dd6cde0eb1e;
      7'd67: round_const = 64'hf57d4f7fee6ed178;
      7'd68: round_const = 64'h06f067aa72176fba;
      7'd69: round_const = 64'h0a637dc5a2c898a6;
      7'd70: round_const = 64'h113f9804bef90dae;
      7'd71: round_const = 64'h1b710b35131c471b;
      7'd72: round_const = 64'h28db77f523047d84;
      7'd73: round_const = 64'h32caab7b40c72493;
      7'd74: round_const = 64'h3c9ebe0a15c9bebc;
      7'd75: round_const = 64'h431d67c49c100d4c;
      7'd76: round_const = 64'h4cc5d4becb3e42b6;
      7'd77: round_const = 64'h597f299cfc657e2a;
      7'd78: round_const = 64'h5fcb6fab3ad6faec;
      7'd79: round_const = 64'h6c44198c4a475817;
      default: round_const = 64'h0;
    endcase
  endfunction

endpackage

@@ src/sha_multi_mode_digest.sv @@
// Multi-mode SHA digest engine (SHA-1, SHA-256, SHA-384, SHA-512).
// One round unit shared by all modes, run by a small sequencer.
// Depends on sha_md_pkg.
//
//  Channel | Direction | Signals
//  --------+-----------+--------------------------------------------------
//  input   | in        | in_valid_i, in_stall_o, cmd_i, data_byte_i
//  output  | out       | out_valid_o, out_stall_i, digest_word_o,
//          |           | valid_bytes_o, last_word_o
//  config  | in        | cfg_we_i, cfg_wdata_i (algo_mode)
//
// A byte that completes a block adds one round per cycle (80 for SHA-1/384/512,
// 64 for SHA-256) plus a feed-forward step, all in the shared round unit. A
// finish pushes padding one byte per cycle, compresses once or twice, then
// offers one digest word per cycle while not stalled. Reset loads SHA-256
// initial values. Input is stalled whenever busy; a stalled digest word holds
// until taken.
module sha_multi_mode_digest
  import sha_md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  logic [1:0]  mode_q;
  logic [63:0] hash_q [8];
  logic [63:0] var_q [8];
  logic [63:0] win_q [16];
  logic [55:0] acc_q;
  logic [63:0] count_q;
  logic [6:0]  fill_q;
  logic [6:0]  rnd_q;
  logic [2:0]  wcnt_q;
  logic [3:0]  len_idx_q;
  pad_e        pad_q;
  logic        fin_q;
  logic        pad_done_q;

  logic        wide;
  logic        in_acc;
  logic        out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        word_done;
  logic        blk_done;
  logic [7:0]  fill_inc;
  logic [63:0] push_word;
  logic [127:0] len_bits;
  logic [6:0]  len_pos;
  logic        len_last;
  logic        rnd_last;
  logic        out_last;
  logic [2:0]  nwords_m1;

  assign wide    = mode_q[1];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Message length in bits, 128 bits wide.
  assign len_bits = {61'h0, count_q[63:61], count_q[60:0], 3'b000};
  assign len_pos  = wide ? LEN_POS_W64 : LEN_POS_W32;
  assign len_last = (len_idx_q == 4'd15);

  // Byte push selection: message bytes while idle, padding bytes while padding.
  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    if (state_q == ST_IDLE) begin
      push_en   = in_acc && (cmd_i == CMD_ABSORB || cmd_i == CMD_ABSORB_FIN);
      push_byte = data_byte_i;
    end else if (state_q == ST_PAD) begin
      push_en = 1'b1;
      unique case (pad_q)
        PAD_MARK: push_byte = PAD_MARKER;
        PAD_ZERO: push_byte = (fill_q != len_pos) ? 8'h00
                            : len_bits[8 * (15 - (wide ? 0 : 8)) +: 8];
        default:  push_byte = len_bits[8 * (15 - int'(len_idx_q)) +: 8];
      endcase
    end
  end

  assign fill_inc  = {1'b0, fill_q} + 8'd1;
  assign word_done = wide ? (fill_q[2:0] == 3'd7) : (fill_q[1:0] == 2'd3);
  assign blk_done  = push_en && (fill_inc == (wide ? 8'd128 : 8'd64));
  assign push_word = wide ? {acc_q, push_byte} : {32'h0, acc_q[23:0], push_byte};

  // Shared round unit.
  logic [63:0] ra, rb, rc, rd, re, rf, rg, rh, w0, kc;
  logic [63:0] s0, s1, ch, mj, t1, t2;
  logic [31:0] f1, k1, t1a;
  logic [63:0] na, ne;
  logic [63:0] sched;
  logic [31:0] ws0, ws1;
  logic [63:0] wl0, wl1;

  always_comb begin
    ra = var_q[0]; rb = var_q[1]; rc = var_q[2]; rd = var_q[3];
    re = var_q[4]; rf = var_q[5]; rg = var_q[6]; rh = var_q[7];
    w0 = win_q[0];
    kc = round_const(rnd_q);
    s0 = 64'h0; s1 = 64'h0; ch = 64'h0; mj = 64'h0; t1 = 64'h0; t2 = 64'h0;
    f1 = 32'h0; k1 = 32'h0; t1a = 32'h0;
    na = 64'h0; ne = 64'h0;
    ws0 = 32'h0; ws1 = 32'h0; wl0 = 64'h0; wl1 = 64'h0; sched = 64'h0;
    unique case (mode_q)
      MODE_SHA1: begin
        if (rnd_q < 7'd20) begin
          f1 = (rb[31:0] & rc[31:0]) | (~rb[31:0] & rd[31:0]); k1 = K1_0;
        end else if (rnd_q < 7'd40) begin
          f1 = rb[31:0] ^ rc[31:0] ^ rd[31:0]; k1 = K1_1;
        end else if (rnd_q < 7'd60) begin
          f1 = (rb[31:0] & rc[31:0]) | (rb[31:0] & rd[31:0]) | (rc[31:0] & rd[31:0]);
          k1 = K1_2;
        end else begin
          f1 = rb[31:0] ^ rc[31:0] ^ rd[31:0]; k1 = K1_3;
        end
        t1a = rotr32(ra[31:0], 27) + f1 + re[31:0] + k1 + w0[31:0];
        na  = {32'h0, t1a};
        sched = {32'h0, rotr32(win_q[13][31:0] ^ win_q[8][31:0] ^ win_q[2][31:0]
                               ^ win_q[0][31:0], 31)};
      end
      MODE_SHA256: begin
        s1[31:0] = rotr32(re[31:0], 6) ^ rotr32(re[31:0], 11) ^ rotr32(re[31:0], 25);
        ch[31:0] = (re[31:0] & rf[31:0]) ^ (~re[31:0] & rg[31:0]);
        t1[31:0] = rh[31:0] + s1[31:0] + ch[31:0] + kc[63:32] + w0[31:0];
        s0[31:0] = rotr32(ra[31:0], 2) ^ rotr32(ra[31:0], 13) ^ rotr32(ra[31:0], 22);
        mj[31:0] = (ra[31:0] & rb[31:0]) ^ (ra[31:0] & rc[31:0]) ^ (rb[31:0] & rc[31:0]);
        t2[31:0] = s0[31:0] + mj[31:0];
        na = {32'h0, t1[31:0] + t2[31:0]};
        ne = {32'h0, rd[31:0] + t1[31:0]};
        ws0 = rotr32(win_q[1][31:0], 7) ^ rotr32(win_q[1][31:0], 18) ^ (win_q[1][31:0] >> 3);
        ws1 = rotr32(win_q[14][31:0], 17) ^ rotr32(win_q[14][31:0], 19)
            ^ (win_q[14][31:0] >> 10);
        sched = {32'h0, win_q[0][31:0] + ws0 + win_q[9][31:0] + ws1};
      end
      default: begin
        s1 = rotr64(re, 14) ^ rotr64(re, 18) ^ rotr64(re, 41);
        ch = (re & rf) ^ (~re & rg);
        t1 = rh + s1 + ch + kc + w0;
        s0 = rotr64(ra, 28) ^ rotr64(ra, 34) ^ rotr64(ra, 39);
        mj = (ra & rb) ^ (ra & rc) ^ (rb & rc);
        t2 = s0 + mj;
        na = t1 + t2;
        ne = rd + t1;
        wl0 = rotr64(win_q[1], 1) ^ rotr64(win_q[1], 8) ^ (win_q[1] >> 7);
        wl1 = rotr64(win_q[14], 19) ^ rotr64(win_q[14], 61) ^ (win_q[14] >> 6);
        sched = win_q[0] + wl0 + win_q[9] + wl1;
      end
    endcase
  end

  assign rnd_last = (rnd_q == ((mode_q == MODE_SHA256) ? 7'd63 : 7'd79));

  // Digest word selection.
  always_comb begin
    unique case (mode_q)
      MODE_SHA1:   nwords_m1 = 3'd2;
      MODE_SHA256: nwords_m1 = 3'd3;
      MODE_SHA384: nwords_m1 = 3'd5;
      default:     nwords_m1 = 3'd7;
    endcase
    out_last = (wcnt_q == nwords_m1);
    if (!wide) begin
      digest_word_o = {hash_q[{wcnt_q[1:0], 1'b0}][31:0], hash_q[{wcnt_q[1:0], 1'b1}][31:0]};
    end else begin
      digest_word_o = hash_q[wcnt_q];
    end
    valid_bytes_o = 4'd8;
    if (mode_q == MODE_SHA1 && out_last) begin
      digest_word_o[31:0] = 32'h0;
      valid_bytes_o       = 4'd4;
    end
    last_word_o = out_last;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_done) begin
            state_d = ST_ROUND;
          end else if (cmd_i == CMD_ABSORB_FIN || cmd_i == CMD_FINISH) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: if (rnd_last) state_d = ST_ADD;
      ST_ADD: begin
        if (pad_done_q) begin
          state_d = ST_OUT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: if (blk_done) state_d = ST_ROUND;
      ST_OUT: if (out_acc && out_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  // Control and hash state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_SHA256;
      count_q    <= '0;
      fill_q     <= '0;
      rnd_q      <= '0;
      wcnt_q     <= '0;
      len_idx_q  <= '0;
      pad_q      <= PAD_MARK;
      fin_q      <= 1'b0;
      pad_done_q <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= init_value(MODE_SHA256, 3'(i));
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q  <= cfg_wdata_i;
        count_q <= '0;
        fill_q  <= '0;
        for (int i = 0; i < 8; i++) hash_q[i] <= init_value(cfg_wdata_i, 3'(i));
      end else begin
        // Byte accounting.
        if (state_q == ST_IDLE && push_en) count_q <= count_q + 64'd1;
        if (push_en) fill_q <= blk_done ? 7'd0 : fill_inc[6:0];
        if (state_q == ST_IDLE && in_acc
            && (cmd_i == CMD_ABSORB_FIN || cmd_i == CMD_FINISH)) begin
          fin_q <= 1'b1;
        end
        // Padding sequence.
        if (state_q == ST_PAD) begin
          unique case (pad_q)
            PAD_MARK: pad_q <= PAD_ZERO;
            PAD_ZERO: begin
              if (fill_q == len_pos) begin
                pad_q     <= PAD_LEN;
                len_idx_q <= wide ? 4'd1 : 4'd9;
              end
            end
            default: begin
              len_idx_q <= len_idx_q + 4'd1;
              if (len_last) pad_done_q <= 1'b1;
            end
          endcase
        end
        // Round counter.
        if (state_q == ST_ROUND) begin
          rnd_q <= rnd_last ? 7'd0 : rnd_q + 7'd1;
        end
        // Feed-forward.
        if (state_q == ST_ADD) begin
          for (int i = 0; i < 8; i++) begin
            if (!wide) begin
              if (mode_q != MODE_SHA1 || i < 5) begin
                hash_q[i] <= {32'h0, hash_q[i][31:0] + var_q[i][31:0]};
              end
            end else begin
              hash_q[i] <= hash_q[i] + var_q[i];
            end
          end
        end
        // Digest output and reload for the next message.
        if (out_acc) begin
          if (out_last) begin
            wcnt_q     <= '0;
            count_q    <= '0;
            fill_q     <= '0;
            fin_q      <= 1'b0;
            pad_done_q <= 1'b0;
            pad_q      <= PAD_MARK;
            for (int i = 0; i < 8; i++) hash_q[i] <= init_value(mode_q, 3'(i));
          end else begin
            wcnt_q <= wcnt_q + 3'd1;
          end
        end
      end
    end
  end

  // Datapath: byte gatherer, schedule window and working variables.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      acc_q <= {acc_q[47:0], push_byte};
      if (word_done) begin
        for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
        win_q[15] <= push_word;
      end
    end
    if (blk_done) begin
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
    end
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= sched;
      if (mode_q == MODE_SHA1) begin
        var_q[0] <= na;
        var_q[1] <= var_q[0];
        var_q[2] <= {32'h0, rotr32(var_q[1][31:0], 2)};
        var_q[3] <= var_q[2];
        var_q[4] <= var_q[3];
      end else begin
        var_q[0] <= na;
        var_q[1] <= var_q[0];
        var_q[2] <= var_q[1];
        var_q[3] <= var_q[2];
        var_q[4] <= ne;
        var_q[5] <= var_q[4];
        var_q[6] <= var_q[5];
        var_q[7] <= var_q[6];
      end
    end
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for sha_multi_mode_digest: byte streams in all four modes.
// Holds its own SHA-1/256/384/512 predictor and compares every digest word in order.
// Depends on sha_md_pkg and sha_multi_mode_digest.
`timescale 1ns / 1ps

module tb;
  import sha_md_pkg::*;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } digest_word_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  // SHA-512 round constants; the upper halves serve SHA-256.
  localparam logic [63:0] RC [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] IV_512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] IV_384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };
  localparam logic [31:0] IV_1 [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_word_o;
  logic [3:0]  valid_bytes_o;
  logic        last_word_o;

  sha_multi_mode_digest u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .valid_bytes_o(valid_bytes_o),
    .last_word_o  (last_word_o)
  );

  byte_item_t   pending_q[$];
  digest_word_t digest_q[$];
  int           fail_count;
  int           idle_cycles;

  // Shadow of the hashing state.
  logic [1:0]  sh_mode;
  logic [63:0] sh_hash [8];
  logic [63:0] sh_count;
  logic [7:0]  sh_block [128];
  int          sh_fill;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Load the initial values of the current mode and drop any partial message.
  task automatic load_start_values();
    for (int i = 0; i < 8; i++) begin
      case (sh_mode)
        MODE_SHA1:   sh_hash[i] = (i < 5) ? {32'h0, IV_1[i]} : 64'h0;
        MODE_SHA256: sh_hash[i] = {32'h0, IV_512[i][63:32]};
        MODE_SHA384: sh_hash[i] = IV_384[i];
        default:     sh_hash[i] = IV_512[i];
      endcase
    end
    sh_count = '0;
    sh_fill = 0;
  endtask

  // Compress the full block buffer into the hash state.
  task automatic compress_block();
    logic [31:0] w32 [80];
    logic [31:0] v32 [8];
    logic [63:0] w64 [80];
    logic [63:0] v64 [8];
    logic [31:0] f, k, t1, t2, s0, s1;
    logic [63:0] u0, u1, x1, x2;
    if (sh_mode == MODE_SHA1) begin
      for (int i = 0; i < 16; i++)
        w32[i] = {sh_block[4*i], sh_block[4*i+1], sh_block[4*i+2], sh_block[4*i+3]};
      for (int i = 16; i < 80; i++) begin
        f = w32[i-3] ^ w32[i-8] ^ w32[i-14] ^ w32[i-16];
        w32[i] = {f[30:0], f[31]};
      end
      for (int i = 0; i < 5; i++) v32[i] = sh_hash[i][31:0];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (v32[1] & v32[2]) | (~v32[1] & v32[3]);
          k = K1_0;
        end else if (i < 40) begin
          f = v32[1] ^ v32[2] ^ v32[3];
          k = K1_1;
        end else if (i < 60) begin
          f = (v32[1] & v32[2]) | (v32[1] & v32[3]) | (v32[2] & v32[3]);
          k = K1_2;
        end else begin
          f = v32[1] ^ v32[2] ^ v32[3];
          k = K1_3;
        end
        t1 = {v32[0][26:0], v32[0][31:27]} + f + v32[4] + k + w32[i];
        v32[4] = v32[3];
        v32[3] = v32[2];
        v32[2] = {v32[1][1:0], v32[1][31:2]};
        v32[1] = v32[0];
        v32[0] = t1;
      end
      for (int i = 0; i < 5; i++) sh_hash[i] = {32'h0, sh_hash[i][31:0] + v32[i]};
    end else if (sh_mode == MODE_SHA256) begin
      for (int i = 0; i < 16; i++)
        w32[i] = {sh_block[4*i], sh_block[4*i+1], sh_block[4*i+2], sh_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w32[i-15], 7) ^ ror32(w32[i-15], 18) ^ (w32[i-15] >> 3);
        s1 = ror32(w32[i-2], 17) ^ ror32(w32[i-2], 19) ^ (w32[i-2] >> 10);
        w32[i] = w32[i-16] + s0 + w32[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v32[i] = sh_hash[i][31:0];
      for (int i = 0; i < 64; i++) begin
        s1 = ror32(v32[4], 6) ^ ror32(v32[4], 11) ^ ror32(v32[4], 25);
        t1 = v32[7] + s1 + ((v32[4] & v32[5]) ^ (~v32[4] & v32[6])) + RC[i][63:32] + w32[i];
        s0 = ror32(v32[0], 2) ^ ror32(v32[0], 13) ^ ror32(v32[0], 22);
        t2 = s0 + ((v32[0] & v32[1]) ^ (v32[0] & v32[2]) ^ (v32[1] & v32[2]));
        for (int j = 7; j > 0; j--) v32[j] = v32[j-1];
        v32[4] = v32[4] + t1;
        v32[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) sh_hash[i] = {32'h0, sh_hash[i][31:0] + v32[i]};
    end else begin
      for (int i = 0; i < 16; i++)
        for (int j = 0; j < 8; j++) w64[i][63-8*j -: 8] = sh_block[8*i+j];
      for (int i = 16; i < 80; i++) begin
        u0 = ror64(w64[i-15], 1) ^ ror64(w64[i-15], 8) ^ (w64[i-15] >> 7);
        u1 = ror64(w64[i-2], 19) ^ ror64(w64[i-2], 61) ^ (w64[i-2] >> 6);
        w64[i] = w64[i-16] + u0 + w64[i-7] + u1;
      end
      for (int i = 0; i < 8; i++) v64[i] = sh_hash[i];
      for (int i = 0; i < 80; i++) begin
        u1 = ror64(v64[4], 14) ^ ror64(v64[4], 18) ^ ror64(v64[4], 41);
        x1 = v64[7] + u1 + ((v64[4] & v64[5]) ^ (~v64[4] & v64[6])) + RC[i] + w64[i];
        u0 = ror64(v64[0], 28) ^ ror64(v64[0], 34) ^ ror64(v64[0], 39);
        x2 = u0 + ((v64[0] & v64[1]) ^ (v64[0] & v64[2]) ^ (v64[1] & v64[2]));
        for (int j = 7; j > 0; j--) v64[j] = v64[j-1];
        v64[4] = v64[4] + x1;
        v64[0] = x1 + x2;
      end
      for (int i = 0; i < 8; i++) sh_hash[i] = sh_hash[i] + v64[i];
    end
  endtask

  task automatic buffer_byte(input logic [7:0] b);
    sh_block[sh_fill] = b;
    sh_fill++;
    if (sh_fill == ((sh_mode < MODE_SHA384) ? 64 : 128)) begin
      compress_block();
      sh_fill = 0;
    end
  endtask

  // Apply one accepted word and queue the digest words that a finish produces.
  task automatic predict_digest(input byte_item_t it);
    logic [63:0]  bits;
    logic [63:0]  mask;
    int           bsize, len_bytes, total, nwords, nb;
    digest_word_t d;
    if (it.cmd == CMD_ABSORB || it.cmd == CMD_ABSORB_FIN) begin
      sh_count++;
      buffer_byte(it.data);
    end
    if (it.cmd != CMD_FINISH && it.cmd != CMD_ABSORB_FIN) return;
    bsize = (sh_mode < MODE_SHA384) ? 64 : 128;
    len_bytes = (sh_mode < MODE_SHA384) ? 8 : 16;
    bits = sh_count << 3;
    buffer_byte(PAD_MARKER);
    while (sh_fill != bsize - len_bytes) buffer_byte(8'h00);
    // The upper length half holds only the three bits shifted out of the count.
    if (len_bytes == 16) begin
      for (int i = 0; i < 7; i++) buffer_byte(8'h00);
      buffer_byte({5'h0, sh_count[63:61]});
    end
    for (int i = 0; i < 8; i++) buffer_byte(bits[63-8*i -: 8]);
    case (sh_mode)
      MODE_SHA1:   total = 20;
      MODE_SHA256: total = 32;
      MODE_SHA384: total = 48;
      default:     total = 64;
    endcase
    nwords = (total + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      nb = (total - 8 * k > 8) ? 8 : total - 8 * k;
      mask = (nb == 8) ? '1 : ~(64'hffff_ffff_ffff_ffff >> (8 * nb));
      if (sh_mode < MODE_SHA384)
        d.word = {sh_hash[2*k][31:0], sh_hash[2*k+1][31:0]} & mask;
      else
        d.word = sh_hash[k] & mask;
      d.nbytes = 4'(nb);
      d.last = (k == nwords - 1);
      digest_q.push_back(d);
    end
    load_start_values();
  endtask

  // Driver: bursts of words with random gaps; a stalled word is held.
  int         burst_left;
  int         gap_left;
  always @(posedge clk_i) begin
    logic       taken;
    byte_item_t nxt;
    taken = in_valid_i && !in_stall_o;
    if (taken) predict_digest('{cmd: cmd_i, data: data_byte_i});
    if (rst_ni && (!in_valid_i || taken)) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        nxt = pending_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= nxt.cmd;
        data_byte_i <= nxt.data;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern changes character, redrawn at random from four levels.
  int stall_phase;
  int stall_level;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_level <= $urandom_range(0, 3);
    case (stall_level)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (stall_phase % 8) < 5;
    endcase
  end

  // Monitor: each digest word against the oldest expectation.
  always @(posedge clk_i) begin
    digest_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", digest_word_o, 64'h0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) report_mismatch("digest", digest_word_o, want.word);
        if (valid_bytes_o !== want.nbytes)
          report_mismatch("valid_bytes", 64'(valid_bytes_o), 64'(want.nbytes));
        if (last_word_o !== want.last)
          report_mismatch("last_word", 64'(last_word_o), 64'(want.last));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_word(input logic [1:0] c, input logic [7:0] b);
    pending_q.push_back('{cmd: c, data: b});
  endtask

  // A message of random bytes, ended either on its last byte or by a bare finish.
  task automatic add_message(input int len);
    bit on_last;
    on_last = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_word(CMD_NONE, 8'($urandom_range(0, 255)));
      add_word((on_last && i == len - 1) ? CMD_ABSORB_FIN : CMD_ABSORB,
               8'($urandom_range(0, 255)));
    end
    if (!on_last) add_word(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_quiet();
    wait (pending_q.size() == 0 && !in_valid_i && digest_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_mode = m;
    load_start_values();
  endtask

  initial begin
    int long_len [8] = '{55, 56, 63, 64, 111, 112, 127, 128};
    logic [1:0] modes [6] = '{MODE_SHA256, MODE_SHA1, MODE_SHA384, MODE_SHA512, MODE_SHA1,
                              MODE_SHA512};
    int budget;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = MODE_SHA1;
    in_valid_i = 1'b0;
    cmd_i = CMD_ABSORB;
    data_byte_i = 8'h00;
    out_stall_i = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    stall_level = 0;
    fail_count = 0;
    idle_cycles = 0;
    sh_mode = MODE_SHA256;
    load_start_values();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, ignored command three, "abc", byte extremes.
    add_word(CMD_FINISH, 8'hff);
    add_word(CMD_NONE, 8'h5a);
    add_word(CMD_ABSORB, 8'h61);
    add_word(CMD_ABSORB, 8'h62);
    add_word(CMD_NONE, 8'hff);
    add_word(CMD_ABSORB_FIN, 8'h63);
    add_word(CMD_ABSORB, 8'h00);
    add_word(CMD_ABSORB, 8'hff);
    add_word(CMD_ABSORB_FIN, 8'haa);
    add_word(CMD_FINISH, 8'h00);
    // A partial message is abandoned by rewriting the same mode.
    add_word(CMD_ABSORB, 8'h55);
    add_word(CMD_ABSORB, 8'h0f);
    wait_quiet();
    write_mode(MODE_SHA256);
    add_word(CMD_FINISH, 8'h3c);
    wait_quiet();

    // Random messages in a sequence of modes, extremes included.
    foreach (modes[p]) begin
      write_mode(modes[p]);
      add_message(0);
      budget = 8;
      while (budget > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          add_message(long_len[$urandom_range(0, 7)]);
          budget -= 20;
        end else begin
          budget -= $urandom_range(1, 12);
          add_message($urandom_range(0, 12));
        end
      end
      // Leave a partial message for the next mode write to abandon.
      if ($urandom_range(0, 1)) for (int i = 0; i < 5; i++) add_word(CMD_ABSORB, 8'hc3);
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sha_md_pkg.sv
src/sha_multi_mode_digest.sv
test/tb.sv
